@@ rtl/core/rdsc_pkg.sv @@
// ----------------------------------------------------------------------------
// rdsc_pkg: shared types, disk tables and lookups
// Fixed 24-symbol outer and inner disks, symbol search, mod-24 helpers.
// ----------------------------------------------------------------------------
package rdsc_pkg;

  localparam int DISK_SIZE = 24;
  localparam int POS_W     = 5;

  localparam logic [8*DISK_SIZE-1:0] OUTER_STR = "ABCDEFGILMNOPQRSTVXZ1234";
  localparam logic [8*DISK_SIZE-1:0] INNER_STR = "mqihfdbacegklnprtuz&xyso";

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_DIRECTION = 2'd0,
    CFG_MODE      = 2'd1,
    CFG_START     = 2'd2
  } rdsc_cfg_idx_t;

  // mode controls handed to the transform
  typedef struct packed {
    logic decrypt;
    logic alpha_mode;
  } rdsc_ctrl_t;

  // transform result
  typedef struct packed {
    logic [7:0]       char_out;
    logic             rotated;
    logic [POS_W-1:0] offset;
  } rdsc_res_t;

  typedef struct packed {
    logic             hit;
    logic [POS_W-1:0] pos;
  } rdsc_hit_t;

  function automatic logic [7:0] outer_sym(input logic [POS_W-1:0] pos);
    return OUTER_STR[8*(DISK_SIZE-1-int'(pos)) +: 8];
  endfunction

  function automatic logic [7:0] inner_sym(input logic [POS_W-1:0] pos);
    return INNER_STR[8*(DISK_SIZE-1-int'(pos)) +: 8];
  endfunction

  function automatic rdsc_hit_t find_outer(input logic [7:0] c);
    rdsc_hit_t r;
    r = '0;
    for (int i = 0; i < DISK_SIZE; i++) begin
      if (!r.hit && OUTER_STR[8*(DISK_SIZE-1-i) +: 8] == c) begin
        r.hit = 1'b1;
        r.pos = POS_W'(i);
      end
    end
    return r;
  endfunction

  function automatic rdsc_hit_t find_inner(input logic [7:0] c);
    rdsc_hit_t r;
    r = '0;
    for (int i = 0; i < DISK_SIZE; i++) begin
      if (!r.hit && INNER_STR[8*(DISK_SIZE-1-i) +: 8] == c) begin
        r.hit = 1'b1;
        r.pos = POS_W'(i);
      end
    end
    return r;
  endfunction

  // fold a 5-bit value into 0..23
  function automatic logic [POS_W-1:0] fold24(input logic [POS_W-1:0] v);
    return (v >= POS_W'(DISK_SIZE)) ? POS_W'(v - POS_W'(DISK_SIZE)) : v;
  endfunction

  // (a + b) mod 24, both below 24
  function automatic logic [POS_W-1:0] add24(input logic [POS_W-1:0] a,
                                             input logic [POS_W-1:0] b);
    logic [POS_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (POS_W+1)'(DISK_SIZE)) begin
      s = s - (POS_W+1)'(DISK_SIZE);
    end
    return s[POS_W-1:0];
  endfunction

  // (a - b) mod 24, both below 24
  function automatic logic [POS_W-1:0] sub24(input logic [POS_W-1:0] a,
                                             input logic [POS_W-1:0] b);
    return (a >= b) ? POS_W'(a - b) : POS_W'(a + POS_W'(DISK_SIZE) - b);
  endfunction

endpackage

@@ rtl/core/rdsc_xform.sv @@
// ----------------------------------------------------------------------------
// rdsc_xform: single-character cipher transform
// Combinational substitution and disk realignment for one character.
// ----------------------------------------------------------------------------
module rdsc_xform (
  input  logic [7:0]                char_in,
  input  logic [rdsc_pkg::POS_W-1:0] offset,
  input  rdsc_pkg::rdsc_ctrl_t      ctrl,
  output rdsc_pkg::rdsc_res_t       res
);

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MARK  = 8'h23;

  function automatic logic is_up(input logic [7:0] c);
    return (c >= 8'h41) && (c <= 8'h5A);
  endfunction

  function automatic logic is_low(input logic [7:0] c);
    return (c >= 8'h61) && (c <= 8'h7A);
  endfunction

  function automatic logic [7:0] to_up(input logic [7:0] c);
    return is_low(c) ? 8'(c - 8'd32) : c;
  endfunction

  function automatic logic [7:0] to_low(input logic [7:0] c);
    return is_up(c) ? 8'(c + 8'd32) : c;
  endfunction

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

  function automatic logic is_digit14(input logic [7:0] c);
    return (c >= 8'h31) && (c <= 8'h34);
  endfunction

  rdsc_pkg::rdsc_hit_t       fo;        // plaintext on outer disk
  rdsc_pkg::rdsc_hit_t       fi;        // ciphertext on inner disk
  rdsc_pkg::rdsc_hit_t       fr;        // realign symbol on inner disk
  logic [rdsc_pkg::POS_W-1:0] enc_idx;
  logic [rdsc_pkg::POS_W-1:0] dec_idx;
  logic [7:0]                enc_sym;
  logic [7:0]                dec_sym;
  logic [7:0]                fr_key;
  logic [7:0]                ch;
  logic [rdsc_pkg::POS_W-1:0] offs;

  assign fo      = rdsc_pkg::find_outer(to_up(char_in));
  assign fi      = rdsc_pkg::find_inner(ctrl.alpha_mode ? to_low(char_in) : char_in);
  assign enc_idx = rdsc_pkg::add24(fo.pos, offset);
  assign dec_idx = rdsc_pkg::sub24(fi.pos, offset);
  assign enc_sym = rdsc_pkg::inner_sym(enc_idx);
  assign dec_sym = rdsc_pkg::outer_sym(dec_idx);
  // alphabetic realign key: lowercased input (encrypt) or plain symbol (decrypt)
  assign fr_key  = ctrl.decrypt ? to_low(dec_sym) : to_low(char_in);
  assign fr      = rdsc_pkg::find_inner(fr_key);

  always_comb begin
    ch   = char_in;
    offs = offset;
    case ({ctrl.alpha_mode, ctrl.decrypt})
      2'b00: begin
        if (fo.hit) begin
          ch = enc_sym;
          // facing inner symbol sits at enc_idx on the inner disk
          if (is_digit14(char_in)) offs = enc_idx;
        end else begin
          ch = to_up(char_in);
        end
      end
      2'b01: begin
        if (is_ws(char_in) || char_in == CH_DOT || char_in == CH_COMMA) begin
          ch = CH_SPACE;
        end else if (is_up(char_in)) begin
          ch = char_in;
        end else if (fi.hit) begin
          ch = dec_sym;
          if (is_digit14(dec_sym)) offs = fi.pos;
        end
      end
      2'b10: begin
        if (is_ws(char_in)) begin
          ch = CH_SPACE;
        end else if (fo.hit) begin
          ch = enc_sym;
          if (is_up(char_in)) begin
            ch = to_up(enc_sym);
            if (fr.hit) offs = fr.pos;
          end
        end else begin
          ch = CH_MARK;
        end
      end
      default: begin
        if (is_ws(char_in) || char_in == CH_DOT || char_in == CH_COMMA ||
            char_in == CH_MARK) begin
          ch = CH_SPACE;
        end else if (fi.hit) begin
          ch = dec_sym;
          if (is_up(char_in) && fr.hit) offs = fr.pos;
        end
      end
    endcase
  end

  assign res.char_out = ch;
  assign res.offset   = offs;
  assign res.rotated  = (offs != offset);

endmodule

@@ rtl/core/rotating_disk_substitution_cipher.sv @@
// ----------------------------------------------------------------------------
// rotating_disk_substitution_cipher: 24-symbol rotating disk cipher
// One character in, one substituted character out, disk offset carried along.
// ----------------------------------------------------------------------------
// Path: input reg, then result reg; a result held by out_stall keeps the
//   request in the input reg until the result register frees.
// Throughput: 1 character per cycle while out_stall is low; the offset update
//   closes through the single-character transform back into disk_offset_r.
// Reset (rst_n low, synchronous): pipeline empty, disk offset 0,
//   direction encrypt, numeric index mode, start offset 0.
module rotating_disk_substitution_cipher (
  input  logic       clk,
  input  logic       rst_n,
  // input request channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char,
  input  logic       in_restart,
  // result request channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_char,
  output logic       out_rotated,
  // configuration write port
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [4:0] cfg_wdata
);

  localparam int PW = rdsc_pkg::POS_W;

  // configuration
  logic          direction_r;
  logic          mode_r;
  logic [PW-1:0] start_off_r;

  // input stage: holds the accepted request
  logic          s1_valid_r, s1_valid_nxt;
  logic [7:0]    s1_char_r;
  logic          s1_restart_r;

  // disk state
  logic [PW-1:0] disk_offset_r;
  logic [PW-1:0] eff_offset;

  // result stage
  logic          out_valid_r, out_valid_nxt;
  logic [7:0]    out_char_r;
  logic          out_rotated_r;

  logic          in_acc;
  logic          s1_adv;    // input stage moves into result stage

  rdsc_pkg::rdsc_ctrl_t ctrl;
  rdsc_pkg::rdsc_res_t  xres;

  // --------------------------------------------------------------------------
  // Configuration writes; unknown indexes are dropped.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      direction_r <= 1'b0;
      mode_r      <= 1'b0;
      start_off_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        rdsc_pkg::CFG_DIRECTION: direction_r <= cfg_wdata[0];
        rdsc_pkg::CFG_MODE:      mode_r      <= cfg_wdata[0];
        rdsc_pkg::CFG_START:     start_off_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Handshake. The result register frees when it is empty or being taken;
  // the input stage then moves forward and can refill in the same cycle.
  // --------------------------------------------------------------------------
  assign s1_adv        = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall      = s1_valid_r && !s1_adv;
  assign in_acc        = in_valid && !in_stall;
  assign s1_valid_nxt  = in_acc || (s1_valid_r && !s1_adv);
  assign out_valid_nxt = s1_adv || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_char_r    <= in_char;
      s1_restart_r <= in_restart;
    end
  end

  // --------------------------------------------------------------------------
  // Transform. Restart reloads the offset (start value folded mod 24)
  // before the character is handled; rotated only reflects the character.
  // --------------------------------------------------------------------------
  assign eff_offset   = s1_restart_r ? rdsc_pkg::fold24(start_off_r) : disk_offset_r;
  assign ctrl.decrypt    = direction_r;
  assign ctrl.alpha_mode = mode_r;

  rdsc_xform u_xform (
    .char_in (s1_char_r),
    .offset  (eff_offset),
    .ctrl    (ctrl),
    .res     (xres)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      disk_offset_r <= '0;
    end else if (s1_adv) begin
      disk_offset_r <= xres.offset;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_char_r    <= xres.char_out;
      out_rotated_r <= xres.rotated;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_char    = out_char_r;
  assign out_rotated = out_rotated_r;

`ifndef ASSERT_OFF
  // disk offset stays on the disk
  a_offset_range: assert property (@(posedge clk) disable iff (!rst_n)
    disk_offset_r < PW'(rdsc_pkg::DISK_SIZE))
    else $error("disk offset out of range");

  // a request leaving the input stage lands in the result register
  a_adv_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("result register not loaded");

  // a held request is not dropped
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |=> (s1_valid_r && $stable(s1_char_r)))
    else $error("input stage lost a request");

  // stall only with a full input stage
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r)
    else $error("stall with empty input stage");
`endif

endmodule
